// ===== hw/rtl/spc_pkg.sv =====
// shared constants and types for the scan polar-to-cartesian block
// no dependencies
`default_nettype none

package spc_pkg;

	// default sizes
	localparam int RANGE_BITS_DEF = 16;
	localparam int PHASE_BITS_DEF = 24;
	localparam int CORDIC_ITERATIONS_DEF = 16;

	// fixed-point format of the rotating vector
	localparam int FRAC_BITS = 24;
	localparam int HEADROOM_BITS = 2;
	localparam int TURN_BITS = 32;
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

	// register map
	localparam int REG_ADDR_BITS = 3;
	localparam logic REG_START_ANGLE = 1'b0;
	localparam logic REG_ANGLE_STEP = 1'b1;

	// quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic start;   // load product and residual angle
		logic init;    // round product into x, clear y
		logic step;    // one micro-rotation
	} spc_rot_ctrl_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spc_regs.sv =====
// apb configuration registers: start angle and per-beam angle step
// depends on spc_pkg
`default_nettype none

module spc_regs #(
	parameter int PHASE_BITS = spc_pkg::PHASE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [spc_pkg::REG_ADDR_BITS-1:0]      paddr,
	input  wire logic [31:0]                            pwdata,
	output logic      [31:0]                            prdata,
	output logic                                        pready,
	output logic      [PHASE_BITS-1:0]                  start_angle,
	output logic      [PHASE_BITS-1:0]                  angle_step
);

	logic [PHASE_BITS-1:0] start_angle_q;
	logic [PHASE_BITS-1:0] angle_step_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				spc_pkg::REG_START_ANGLE: start_angle_q <= PHASE_BITS'(pwdata);
				spc_pkg::REG_ANGLE_STEP:  angle_step_q  <= PHASE_BITS'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			spc_pkg::REG_START_ANGLE: prdata = 32'(start_angle_q);
			spc_pkg::REG_ANGLE_STEP:  prdata = 32'(angle_step_q);
			default:                  prdata = '0;
		endcase
	end

	assign start_angle = start_angle_q;
	assign angle_step  = angle_step_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spc_rotator.sv =====
// shared cordic rotation unit: gain multiply, then one add/shift step per cycle
// depends on spc_pkg
`default_nettype none

module spc_rotator #(
	parameter int RANGE_BITS        = spc_pkg::RANGE_BITS_DEF,
	parameter int CORDIC_ITERATIONS = spc_pkg::CORDIC_ITERATIONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spc_pkg::spc_rot_ctrl_t        ctrl,
	input  wire logic [RANGE_BITS-1:0]         range_value,
	input  wire logic [31:0]                   z_init,
	output logic                               iter_last,
	output logic signed [RANGE_BITS+spc_pkg::FRAC_BITS+spc_pkg::HEADROOM_BITS-1:0] x_out,
	output logic signed [RANGE_BITS+spc_pkg::FRAC_BITS+spc_pkg::HEADROOM_BITS-1:0] y_out
);

	localparam int VW = RANGE_BITS + spc_pkg::FRAC_BITS + spc_pkg::HEADROOM_BITS;
	localparam int MW = RANGE_BITS + 32;
	localparam int IW = $clog2(CORDIC_ITERATIONS);

	logic [MW-1:0]        mul_q;
	logic signed [VW-1:0] x_q;
	logic signed [VW-1:0] y_q;
	logic signed [31:0]   z_q;
	logic [IW-1:0]        iter_q;

	logic [MW:0]          rnd;
	logic signed [VW-1:0] dx;
	logic signed [VW-1:0] dy;
	logic signed [31:0]   ang;

	assign rnd = (MW+1)'(mul_q) + (MW+1)'(128);
	assign dx  = y_q >>> iter_q;
	assign dy  = x_q >>> iter_q;
	assign ang = signed'(spc_pkg::atan_turn(5'(iter_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (ctrl.start) begin
			iter_q <= '0;
		end else if (ctrl.step) begin
			iter_q <= iter_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mul_q <= MW'(range_value) * MW'(spc_pkg::GAIN_Q32);
			z_q   <= signed'(z_init);
		end
		if (ctrl.init) begin
			x_q <= signed'({1'b0, rnd[MW:8]});
			y_q <= '0;
		end else if (ctrl.step) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign iter_last = (iter_q == IW'(CORDIC_ITERATIONS - 1));
	assign x_out     = x_q;
	assign y_out     = y_q;

endmodule

`default_nettype wire

// ===== hw/rtl/scan_polar_to_cartesian.sv =====
// top level: laser range sample to planar point via iterative cordic
// depends on spc_pkg, spc_regs, spc_rotator
`default_nettype none

// channel   signals                                   direction
// input     in_valid, in_stall, range_value,          sample in
//           first_of_scan
// output    out_valid, out_stall, x_coord, y_coord    point out
// config    psel, penable, pwrite, paddr, pwdata,     apb registers
//           prdata, pready
//
// an item holds the single shared rotation unit from one input transfer to the
// next: the gain multiply, the vector load, CORDIC_ITERATIONS micro-rotations
// done one micro-rotation per cycle, then the finish
// in_stall is high from the transfer until the finished point is in the
// output register; the output register frees the unit for the next sample
// while the point waits, and a full stalled output register holds the finish
// reset clears the sequencer, the beam phase and the configuration registers

module scan_polar_to_cartesian #(
	parameter int RANGE_BITS        = spc_pkg::RANGE_BITS_DEF,
	parameter int PHASE_BITS        = spc_pkg::PHASE_BITS_DEF,
	parameter int CORDIC_ITERATIONS = spc_pkg::CORDIC_ITERATIONS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input samples
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [RANGE_BITS-1:0]              range_value,
	input  wire logic                               first_of_scan,
	// output points
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [RANGE_BITS:0]              x_coord,
	output logic signed [RANGE_BITS:0]              y_coord,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [spc_pkg::REG_ADDR_BITS-1:0]  paddr,
	input  wire logic [31:0]                        pwdata,
	output logic      [31:0]                        prdata,
	output logic                                    pready
);

	localparam int VW = RANGE_BITS + spc_pkg::FRAC_BITS + spc_pkg::HEADROOM_BITS;
	localparam int RW = VW - spc_pkg::FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,   // waiting for a sample
		S_LOAD = 4'b0010,   // product rounded into the vector
		S_ITER = 4'b0100,   // micro-rotations
		S_FIN  = 4'b1000    // fold, round, into output register
	} state_t;

	state_t                 state_q;
	state_t                 state_d;
	spc_pkg::spc_rot_ctrl_t rot_ctrl;

	logic [PHASE_BITS-1:0]  start_angle;
	logic [PHASE_BITS-1:0]  angle_step;
	logic [PHASE_BITS-1:0]  beam_phase_q;
	logic [PHASE_BITS-1:0]  phase_sel;
	logic [31:0]            p32;
	logic [1:0]             quad_q;

	logic                   in_xfer;
	logic                   out_xfer;
	logic                   fin_go;
	logic                   iter_last;

	logic signed [VW-1:0]   x_rot;
	logic signed [VW-1:0]   y_rot;
	logic signed [VW-1:0]   fx;
	logic signed [VW-1:0]   fy;
	logic signed [RANGE_BITS:0] x_fin;
	logic signed [RANGE_BITS:0] y_fin;

	logic                   out_valid_q;
	logic signed [RANGE_BITS:0] x_q;
	logic signed [RANGE_BITS:0] y_q;

	// saturation bound +-(2^RANGE_BITS - 1)
	localparam logic signed [RW-1:0] LIM = signed'(RW'({RANGE_BITS{1'b1}}));

	// round half up by dropping the fraction, then clamp
	function automatic logic signed [RANGE_BITS:0] finish(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] s;
		logic signed [RW-1:0] r;
		logic signed [RW-1:0] c;
		s = v + signed'(VW'(1) <<< (spc_pkg::FRAC_BITS - 1));
		r = RW'(s >>> spc_pkg::FRAC_BITS);
		if (r > LIM) begin
			c = LIM;
		end else if (r < -LIM) begin
			c = -LIM;
		end else begin
			c = r;
		end
		return (RANGE_BITS+1)'(c);
	endfunction

	spc_regs #(
		.PHASE_BITS (PHASE_BITS)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start_angle (start_angle),
		.angle_step  (angle_step)
	);

	// handshakes
	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// beam angle: restart on first beam, else the accumulated phase
	assign phase_sel = first_of_scan ? start_angle : beam_phase_q;
	// widen to a 32-bit turn: top two bits quadrant, rest residual
	assign p32 = 32'(phase_sel) << (spc_pkg::TURN_BITS - PHASE_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_phase_q <= '0;
		end else if (in_xfer) begin
			beam_phase_q <= phase_sel + angle_step;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			quad_q <= p32[31:30];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: state_d = S_ITER;
			S_ITER: begin
				if (iter_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign rot_ctrl.start = in_xfer;
	assign rot_ctrl.init  = (state_q == S_LOAD);
	assign rot_ctrl.step  = (state_q == S_ITER);

	spc_rotator #(
		.RANGE_BITS        (RANGE_BITS),
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_rotator (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (rot_ctrl),
		.range_value (range_value),
		.z_init      ({2'b00, p32[29:0]}),
		.iter_last   (iter_last),
		.x_out       (x_rot),
		.y_out       (y_rot)
	);

	// quadrant fold
	always_comb begin
		case (quad_q)
			spc_pkg::QUAD_1: begin
				fx = -y_rot;
				fy = x_rot;
			end
			spc_pkg::QUAD_2: begin
				fx = -x_rot;
				fy = -y_rot;
			end
			spc_pkg::QUAD_3: begin
				fx = y_rot;
				fy = -x_rot;
			end
			default: begin
				fx = x_rot;
				fy = y_rot;
			end
		endcase
	end

	assign x_fin = finish(fx);
	assign y_fin = finish(fy);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			x_q <= x_fin;
			y_q <= y_fin;
		end
	end

	assign out_valid = out_valid_q;
	assign x_coord   = x_q;
	assign y_coord   = y_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_LOAD))
		else $error("accepted sample did not start the vector load");

	a_last_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) && iter_last |=> (state_q == S_FIN))
		else $error("last rotation did not move to finish");

	a_fin_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && (state_q == S_IDLE))
		else $error("finished point not held in output register");

endmodule

`default_nettype wire
